[rtl/scfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor command framer package
// Shared codes, constants and the burst descriptor type passed from the
// control logic to the beat serializer.
// ----------------------------------------------------------------------------
package scfr_pkg;

  localparam int MAX_PARAMS_DEFAULT = 32;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_PARAM = 2'd1;
  localparam logic [1:0] FUNC_RX    = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_CONFIRM = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  localparam logic REG_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [1:0] FORM_HEADER = 2'd0;
  localparam logic [1:0] FORM_PARAM  = 2'd1;
  localparam logic [1:0] FORM_SINGLE = 2'd2;

  localparam logic [7:0] HDR_BYTE0    = 8'hEF;
  localparam logic [7:0] HDR_BYTE1    = 8'h01;
  localparam logic [7:0] FLAG_COMMAND = 8'h01;
  localparam logic [7:0] FLAG_ACK     = 8'h07;
  localparam logic [7:0] LEN_HIGH     = 8'h00;
  localparam logic [7:0] LEN_OVERHEAD = 8'h03;
  localparam logic [7:0] TIMEOUT_CODE = 8'hFF;

  localparam logic [3:0] POS_LEN_HI  = 4'd7;
  localparam logic [3:0] POS_LEN_LO  = 4'd8;
  localparam logic [3:0] POS_CONFIRM = 4'd9;
  localparam logic [3:0] POS_DATA    = 4'd10;

  typedef struct packed {
    logic [1:0]  form;
    logic [7:0]  data;
    logic [7:0]  len_lo;
    logic        with_sum;
    logic [15:0] sum;
    logic [1:0]  kind;
    logic        last;
  } desc_t;

endpackage
`default_nettype wire

[rtl/scfr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor command framer control
// Updates frame and reply-watch state for each accepted item and
// issues a compact descriptor of the beats that the item produces.
// ----------------------------------------------------------------------------
module scfr_ctrl #(
  parameter int MAX_PARAMS = scfr_pkg::MAX_PARAMS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [1:0]    func,
  input  wire logic [7:0]    data_byte,
  input  wire logic [5:0]    param_count,
  input  wire logic [31:0]   module_address,
  input  wire logic [15:0]   reply_timeout_ticks,
  output scfr_pkg::desc_t    desc,
  output logic               desc_push
);
  import scfr_pkg::*;

  logic [5:0]  params_left, params_left_next;
  logic [15:0] frame_sum, frame_sum_next;
  logic        reply_armed, reply_armed_next;
  logic [15:0] wait_count, wait_count_next;
  logic [3:0]  match_position, match_position_next;
  logic [15:0] reply_length, reply_length_next;
  logic [15:0] reply_bytes_left, reply_bytes_left_next;

  logic [5:0]       cnt_sat;
  logic [7:0]       len_lo;
  logic [15:0]      hdr_sum;
  logic [15:0]      param_sum;
  logic [5:0]       params_dec;
  logic [6:0][7:0]  pat;
  logic [3:0]       fb_pos;
  logic [15:0]      rl_full;
  logic [15:0]      rbl_dec;

  function automatic logic [3:0] fall_back(input logic [6:0][7:0] p, input logic [3:0] k,
                                           input logic [7:0] b);
    logic [3:0] res;
    logic       ok;
    logic [3:0] idx;
    res = 4'd0;
    for (int j = 0; j < 7; j++) begin
      ok = (4'(j) < k) && (p[j] == b);
      for (int i = 0; i < 6; i++) begin
        if (i < j) begin
          idx = k - 4'(j) + 4'(i);
          if (p[i] != p[idx[2:0]]) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        res = 4'(j) + 4'd1;
      end
    end
    return res;
  endfunction

  always_comb begin
    cnt_sat    = (param_count > 6'(MAX_PARAMS)) ? 6'(MAX_PARAMS) : param_count;
    len_lo     = 8'(cnt_sat) + LEN_OVERHEAD;
    hdr_sum    = 16'(FLAG_COMMAND) + 16'(LEN_HIGH) + 16'(len_lo) + 16'(data_byte);
    param_sum  = frame_sum + 16'(data_byte);
    params_dec = params_left - 6'd1;
    pat        = {FLAG_ACK, module_address[7:0], module_address[15:8],
                  module_address[23:16], module_address[31:24], HDR_BYTE1, HDR_BYTE0};
    fb_pos     = fall_back(pat, match_position, data_byte);
    rl_full    = {reply_length[15:8], data_byte};
    rbl_dec    = (reply_bytes_left != 16'd0) ? reply_bytes_left - 16'd1 : 16'd0;
  end

  always_comb begin
    params_left_next      = params_left;
    frame_sum_next        = frame_sum;
    reply_armed_next      = reply_armed;
    wait_count_next       = wait_count;
    match_position_next   = match_position;
    reply_length_next     = reply_length;
    reply_bytes_left_next = reply_bytes_left;
    desc          = '0;
    desc.data     = data_byte;
    desc.len_lo   = len_lo;
    desc_push     = 1'b0;
    if (accept) begin
      unique case (func)
        FUNC_START: begin
          desc_push             = 1'b1;
          desc.form             = FORM_HEADER;
          desc.with_sum         = (cnt_sat == 6'd0);
          desc.sum              = hdr_sum;
          frame_sum_next        = hdr_sum;
          params_left_next      = cnt_sat;
          reply_armed_next      = 1'b0;
          match_position_next   = 4'd0;
          reply_bytes_left_next = 16'd0;
          if (cnt_sat == 6'd0) begin
            reply_armed_next  = 1'b1;
            wait_count_next   = reply_timeout_ticks;
            reply_length_next = 16'd0;
          end
        end
        FUNC_PARAM: begin
          if (params_left != 6'd0) begin
            desc_push        = 1'b1;
            desc.form        = FORM_PARAM;
            desc.with_sum    = (params_dec == 6'd0);
            desc.sum         = param_sum;
            frame_sum_next   = param_sum;
            params_left_next = params_dec;
            if (params_dec == 6'd0) begin
              reply_armed_next      = 1'b1;
              wait_count_next       = reply_timeout_ticks;
              match_position_next   = 4'd0;
              reply_length_next     = 16'd0;
              reply_bytes_left_next = 16'd0;
            end
          end
        end
        FUNC_RX: begin
          if (reply_armed) begin
            if (match_position < POS_LEN_HI) begin
              if (pat[match_position[2:0]] == data_byte) begin
                match_position_next = match_position + 4'd1;
              end else begin
                match_position_next = fb_pos;
              end
            end else if (match_position == POS_LEN_HI) begin
              reply_length_next   = {data_byte, 8'h00};
              match_position_next = POS_LEN_LO;
            end else if (match_position == POS_LEN_LO) begin
              reply_length_next     = rl_full;
              reply_bytes_left_next = (rl_full >= 16'(LEN_OVERHEAD)) ?
                                      rl_full - 16'(LEN_OVERHEAD) : 16'd0;
              match_position_next   = POS_CONFIRM;
            end else if (match_position == POS_CONFIRM) begin
              desc_push = 1'b1;
              desc.form = FORM_SINGLE;
              desc.kind = KIND_CONFIRM;
              desc.last = (reply_bytes_left == 16'd0);
              if (reply_bytes_left == 16'd0) begin
                reply_armed_next    = 1'b0;
                match_position_next = 4'd0;
              end else begin
                match_position_next = POS_DATA;
              end
            end else begin
              desc_push             = 1'b1;
              desc.form             = FORM_SINGLE;
              desc.kind             = KIND_DATA;
              desc.last             = (rbl_dec == 16'd0);
              reply_bytes_left_next = rbl_dec;
              if (rbl_dec == 16'd0) begin
                reply_armed_next    = 1'b0;
                match_position_next = 4'd0;
              end
            end
          end
        end
        FUNC_TICK: begin
          if (reply_armed) begin
            if (wait_count <= 16'd1) begin
              desc_push             = 1'b1;
              desc.form             = FORM_SINGLE;
              desc.kind             = KIND_TIMEOUT;
              desc.data             = TIMEOUT_CODE;
              desc.last             = 1'b1;
              wait_count_next       = 16'd0;
              reply_armed_next      = 1'b0;
              match_position_next   = 4'd0;
              reply_bytes_left_next = 16'd0;
            end else begin
              wait_count_next = wait_count - 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      params_left      <= '0;
      frame_sum        <= '0;
      reply_armed      <= 1'b0;
      wait_count       <= '0;
      match_position   <= '0;
      reply_length     <= '0;
      reply_bytes_left <= '0;
    end else begin
      params_left      <= params_left_next;
      frame_sum        <= frame_sum_next;
      reply_armed      <= reply_armed_next;
      wait_count       <= wait_count_next;
      match_position   <= match_position_next;
      reply_length     <= reply_length_next;
      reply_bytes_left <= reply_bytes_left_next;
    end
  end

endmodule
`default_nettype wire

[rtl/scfr_ser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor command framer beat serializer
// Holds one burst descriptor and turns it into output beats, one per cycle while
// out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module scfr_ser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire scfr_pkg::desc_t desc_in,
  input  wire logic          desc_push,
  input  wire logic [31:0]   module_address,
  input  wire logic          out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output logic [1:0]         kind,
  output logic [7:0]         value,
  output logic               last
);
  import scfr_pkg::*;

  desc_t      desc;
  logic       desc_valid;
  logic [3:0] idx;
  logic [3:0] last_idx;
  logic       load_out;
  logic       emit;
  logic       done;
  logic [1:0] gen_kind;
  logic [7:0] gen_value;
  logic       gen_last;

  always_comb begin
    gen_kind  = KIND_TX;
    gen_value = desc.data;
    gen_last  = 1'b0;
    last_idx  = 4'd0;
    unique case (desc.form)
      FORM_HEADER: begin
        last_idx = desc.with_sum ? 4'd11 : 4'd9;
        gen_last = desc.with_sum && (idx == 4'd11);
        case (idx)
          4'd0:    gen_value = HDR_BYTE0;
          4'd1:    gen_value = HDR_BYTE1;
          4'd2:    gen_value = module_address[31:24];
          4'd3:    gen_value = module_address[23:16];
          4'd4:    gen_value = module_address[15:8];
          4'd5:    gen_value = module_address[7:0];
          4'd6:    gen_value = FLAG_COMMAND;
          4'd7:    gen_value = LEN_HIGH;
          4'd8:    gen_value = desc.len_lo;
          4'd9:    gen_value = desc.data;
          4'd10:   gen_value = desc.sum[15:8];
          default: gen_value = desc.sum[7:0];
        endcase
      end
      FORM_PARAM: begin
        last_idx = desc.with_sum ? 4'd2 : 4'd0;
        gen_last = (idx == 4'd2);
        case (idx)
          4'd0:    gen_value = desc.data;
          4'd1:    gen_value = desc.sum[15:8];
          default: gen_value = desc.sum[7:0];
        endcase
      end
      default: begin
        gen_kind = desc.kind;
        gen_last = desc.last;
      end
    endcase
  end

  assign load_out = !out_valid || !out_stall;
  assign emit     = desc_valid && load_out;
  assign done     = emit && (idx == last_idx);
  assign in_stall = desc_valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      idx        <= '0;
    end else if (done || !desc_valid) begin
      desc_valid <= desc_push;
      idx        <= '0;
    end else if (emit) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (done || !desc_valid) begin
      desc <= desc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind  <= gen_kind;
      value <= gen_value;
      last  <= gen_last;
    end
  end

endmodule
`default_nettype wire

[rtl/sensor_command_framer_reply_parser_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor command framer and reply parser
// Path: an item's descriptor is registered in the serializer; its beats then
// leave the output register one per cycle while out_stall is low. A start
// command gives 10 or 12 beats, a parameter 1 or 3, a reply byte or tick at most one.
// Reset: rst is synchronous; it clears all watch state and restores the
// address to FFFFFFFF and the timeout to 2000 ticks.
// ----------------------------------------------------------------------------
module sensor_command_framer_reply_parser_top #(
  parameter int MAX_PARAMS = scfr_pkg::MAX_PARAMS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  data_byte,
  input  wire logic [5:0]  param_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       value,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import scfr_pkg::*;

  logic [31:0] module_address;
  logic [15:0] reply_timeout_ticks;
  logic        accept;
  desc_t       desc;
  logic        desc_push;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_address      <= 32'hFFFF_FFFF;
      reply_timeout_ticks <= 16'd2000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADDRESS: module_address      <= cfg_data;
        REG_TIMEOUT: reply_timeout_ticks <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  scfr_ctrl #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .accept              (accept),
    .func                (func),
    .data_byte           (data_byte),
    .param_count         (param_count),
    .module_address      (module_address),
    .reply_timeout_ticks (reply_timeout_ticks),
    .desc                (desc),
    .desc_push           (desc_push)
  );

  scfr_ser u_ser (
    .clk            (clk),
    .rst            (rst),
    .desc_in        (desc),
    .desc_push      (desc_push),
    .module_address (module_address),
    .out_stall      (out_stall),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .kind           (kind),
    .value          (value),
    .last           (last)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor command framer and reply parser testbench
// A short stimulus table covers the framing and parsing corners. Random command
// exchanges follow under several address and timeout settings. Every output
// beat is checked against a built-in predictor of the framer, the reply
// matcher and the timeout counter, or against the typed beat of a table row.
// ----------------------------------------------------------------------------
module tb_top;
  import scfr_pkg::*;

  localparam int MAX_PARAMS     = MAX_PARAMS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASE_ITEMS    = 60;
  localparam int N_PHASES       = 8;
  localparam int N_DIRECTED     = 21;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic [5:0] count;
    logic       typed;
    beat_t      beat;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [5:0]  param_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // Predictor state, a copy of the block's registers.
  logic [31:0] addr_reg;
  logic [15:0] timeout_reg;
  logic [5:0]  params_left;
  logic [15:0] frame_sum;
  logic        armed;
  logic [15:0] wait_count;
  logic [3:0]  match_pos;
  logic [15:0] reply_len;
  logic [15:0] reply_left;

  beat_t expected_beats[$];
  beat_t fresh_beats[$];

  int          errors;
  int          used_items;
  int          idle_cycles;
  int          burst_left;
  int          stall_span = 0;
  int          stall_mode = 0;
  bit          cur_typed;
  beat_t       cur_typed_beat;
  logic [31:0] addr_now;
  logic [15:0] timeout_now;

  // Rows with a typed beat expect exactly that single beat.
  row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_TICK,  8'hFF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'h00, 6'd0,  1'b0, '0},
    '{FUNC_PARAM, 8'hFF, 6'd0,  1'b0, '0},
    '{FUNC_START, 8'h00, 6'd63, 1'b0, '0},
    '{FUNC_PARAM, 8'hFF, 6'd0,  1'b1, {KIND_TX, 8'hFF, 1'b0}},
    '{FUNC_START, 8'hFF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'hEF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'hEF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'h01, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'hFF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'hFF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'hFF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'hFF, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'h07, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'h00, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'h01, 6'd0,  1'b0, '0},
    '{FUNC_RX,    8'h00, 6'd0,  1'b1, {KIND_CONFIRM, 8'h00, 1'b1}},
    '{FUNC_RX,    8'h55, 6'd0,  1'b0, '0},
    '{FUNC_START, 8'h80, 6'd1,  1'b0, '0},
    '{FUNC_PARAM, 8'h00, 6'd0,  1'b0, '0},
    '{FUNC_TICK,  8'h00, 6'd0,  1'b0, '0}
  };

  sensor_command_framer_reply_parser_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] header_byte(int idx);
    case (idx)
      0:       return HDR_BYTE0;
      1:       return HDR_BYTE1;
      2:       return addr_reg[31:24];
      3:       return addr_reg[23:16];
      4:       return addr_reg[15:8];
      5:       return addr_reg[7:0];
      default: return FLAG_ACK;
    endcase
  endfunction

  // Longest header prefix that is a suffix of the bytes seen plus the new byte.
  function automatic logic [3:0] fall_back(logic [3:0] k, logic [7:0] b);
    logic [3:0] next_pos;
    bit         same;
    int         i;
    int         j;
    next_pos = 4'd0;
    for (j = int'(k) - 1; j >= 0; j--) begin
      same = (header_byte(j) == b);
      for (i = 0; i < j; i++) begin
        if (header_byte(i) != header_byte(int'(k) - j + i)) same = 1'b0;
      end
      if (same && next_pos == 4'd0) next_pos = 4'(j + 1);
    end
    return next_pos;
  endfunction

  function automatic void push_beat(logic [1:0] k, logic [7:0] v, logic l);
    fresh_beats.push_back({k, v, l});
  endfunction

  function automatic void close_watch();
    armed = 1'b0;
    match_pos = 4'd0;
    reply_left = 16'd0;
  endfunction

  function automatic void send_sum();
    push_beat(KIND_TX, frame_sum[15:8], 1'b0);
    push_beat(KIND_TX, frame_sum[7:0], 1'b1);
    armed = 1'b1;
    wait_count = timeout_reg;
    match_pos = 4'd0;
    reply_len = 16'd0;
    reply_left = 16'd0;
  endfunction

  // Returns 0 when the item leaves the block untouched.
  function automatic bit predict_item(logic [1:0] f, logic [7:0] d, logic [5:0] c);
    logic [5:0]  n;
    logic [15:0] len;
    bit          fin;
    bit          used;
    used = 1'b1;
    case (f)
      FUNC_START: begin
        n = (c > MAX_PARAMS) ? 6'(MAX_PARAMS) : c;
        len = 16'(n) + 16'(LEN_OVERHEAD);
        close_watch();
        push_beat(KIND_TX, HDR_BYTE0, 1'b0);
        push_beat(KIND_TX, HDR_BYTE1, 1'b0);
        push_beat(KIND_TX, addr_reg[31:24], 1'b0);
        push_beat(KIND_TX, addr_reg[23:16], 1'b0);
        push_beat(KIND_TX, addr_reg[15:8], 1'b0);
        push_beat(KIND_TX, addr_reg[7:0], 1'b0);
        push_beat(KIND_TX, FLAG_COMMAND, 1'b0);
        push_beat(KIND_TX, len[15:8], 1'b0);
        push_beat(KIND_TX, len[7:0], 1'b0);
        push_beat(KIND_TX, d, 1'b0);
        frame_sum = 16'(FLAG_COMMAND) + 16'(len[15:8]) + 16'(len[7:0]) + 16'(d);
        params_left = n;
        if (n == 6'd0) send_sum();
      end
      FUNC_PARAM: begin
        if (params_left == 6'd0) begin
          used = 1'b0;
        end else begin
          push_beat(KIND_TX, d, 1'b0);
          frame_sum = frame_sum + 16'(d);
          params_left = params_left - 6'd1;
          if (params_left == 6'd0) send_sum();
        end
      end
      FUNC_RX: begin
        if (!armed) begin
          used = 1'b0;
        end else if (match_pos < POS_LEN_HI) begin
          if (header_byte(match_pos) == d) match_pos = match_pos + 4'd1;
          else match_pos = fall_back(match_pos, d);
        end else if (match_pos == POS_LEN_HI) begin
          reply_len = {d, 8'h00};
          match_pos = POS_LEN_LO;
        end else if (match_pos == POS_LEN_LO) begin
          reply_len = {reply_len[15:8], d};
          reply_left = (reply_len >= 16'd3) ? reply_len - 16'd3 : 16'd0;
          match_pos = POS_CONFIRM;
        end else if (match_pos == POS_CONFIRM) begin
          fin = (reply_left == 16'd0);
          push_beat(KIND_CONFIRM, d, fin);
          if (fin) close_watch();
          else match_pos = POS_DATA;
        end else begin
          if (reply_left != 16'd0) reply_left = reply_left - 16'd1;
          push_beat(KIND_DATA, d, reply_left == 16'd0);
          if (reply_left == 16'd0) close_watch();
        end
      end
      default: begin
        if (!armed) begin
          used = 1'b0;
        end else if (wait_count <= 16'd1) begin
          wait_count = 16'd0;
          push_beat(KIND_TIMEOUT, TIMEOUT_CODE, 1'b1);
          close_watch();
        end else begin
          wait_count = wait_count - 16'd1;
        end
      end
    endcase
    return used;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    beat_t want;
    bit    moved;
    if (rst) begin
      addr_reg = 32'hFFFF_FFFF;
      timeout_reg = 16'd2000;
      params_left = 6'd0;
      frame_sum = 16'd0;
      armed = 1'b0;
      wait_count = 16'd0;
      match_pos = 4'd0;
      reply_len = 16'd0;
      reply_left = 16'd0;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual kind %0d value %02h last %0b",
                   $time, kind, value, last);
        end else begin
          want = expected_beats.pop_front();
          if (kind !== want.kind) report_mismatch("kind", want.kind, kind);
          if (value !== want.value) report_mismatch("value", want.value, value);
          if (last !== want.last) report_mismatch("last", want.last, last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == REG_ADDRESS) addr_reg = cfg_data;
        else timeout_reg = cfg_data[15:0];
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        void'(predict_item(func, data_byte, param_count));
        used_items++;
        if (cur_typed) begin
          expected_beats.push_back(cur_typed_beat);
        end else begin
          while (fresh_beats.size() != 0) expected_beats.push_back(fresh_beats.pop_front());
        end
        fresh_beats.delete();
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // The receiver alternates between free running, light and heavy stalling.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(16, 160);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send_item(logic [1:0] f, logic [7:0] d, logic [5:0] c,
                           bit typed, beat_t typed_beat);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    func = f;
    data_byte = d;
    param_count = c;
    cur_typed = typed;
    cur_typed_beat = typed_beat;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send(logic [1:0] f, logic [7:0] d, logic [5:0] c);
    send_item(f, d, c, 1'b0, '0);
  endtask

  task automatic send_rx(logic [7:0] b);
    if ($urandom_range(0, 9) == 0) send(FUNC_TICK, 8'($urandom), 6'($urandom));
    send(FUNC_RX, b, 6'($urandom));
  endtask

  task automatic wait_drained(int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One command frame, mostly followed by a reply with random content.
  task automatic run_exchange();
    logic [7:0]  hdr [0:6];
    logic [5:0]  c;
    logic [15:0] len;
    int          n_params;
    int          n_sent;
    int          n_data;
    int          i;
    hdr[0] = HDR_BYTE0;
    hdr[1] = HDR_BYTE1;
    hdr[2] = addr_now[31:24];
    hdr[3] = addr_now[23:16];
    hdr[4] = addr_now[15:8];
    hdr[5] = addr_now[7:0];
    hdr[6] = FLAG_ACK;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4)) send(2'($urandom), 8'($urandom), 6'($urandom));
      return;
    end
    case ($urandom_range(0, 9))
      0:       c = 6'($urandom_range(33, 63));
      1:       c = 6'($urandom_range(7, 32));
      default: c = 6'($urandom_range(0, 6));
    endcase
    send(FUNC_START, 8'($urandom), c);
    n_params = (c > MAX_PARAMS) ? MAX_PARAMS : int'(c);
    n_sent = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n_params) : n_params;
    for (i = 0; i < n_sent; i++) send(FUNC_PARAM, 8'($urandom), 6'($urandom));
    if (n_sent != n_params) return;
    if ($urandom_range(0, 9) == 0) begin
      repeat ((timeout_now < 16'd40) ? int'(timeout_now) + 1 : $urandom_range(1, 30)) begin
        send(FUNC_TICK, 8'($urandom), 6'($urandom));
      end
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      send_rx(($urandom_range(0, 1) == 0) ? hdr[$urandom_range(0, 6)] : 8'($urandom));
    end
    for (i = 0; i < 7; i++) send_rx(($urandom_range(0, 14) == 0) ? 8'($urandom) : hdr[i]);
    len[15:8] = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'h00;
    len[7:0] = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
    send_rx(len[15:8]);
    send_rx(len[7:0]);
    send_rx(8'($urandom));
    n_data = (len >= 16'd3) ? int'(len) - 3 : 0;
    if (n_data > 12) n_data = $urandom_range(0, 12);
    for (i = 0; i < n_data; i++) send_rx(8'($urandom));
    repeat ($urandom_range(2, 4)) send_rx(8'($urandom));
  endtask

  initial begin
    int i;
    int phase;
    int phase_goal;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_START;
    data_byte = 8'h00;
    param_count = 6'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_ADDRESS;
    cfg_data = 32'h0;
    errors = 0;
    used_items = 0;
    burst_left = 0;
    cur_typed = 1'b0;
    cur_typed_beat = '0;
    addr_now = 32'hFFFF_FFFF;
    timeout_now = 16'd2000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_rows[i].func, directed_rows[i].data, directed_rows[i].count,
                directed_rows[i].typed, directed_rows[i].beat);
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      wait_drained(SETTLE_CYCLES);
      case (phase)
        0: begin
          addr_now = 32'h0000_0000;
          timeout_now = 16'd1;
        end
        1: begin
          addr_now = 32'hFFFF_FFFF;
          timeout_now = 16'hFFFF;
        end
        2: begin
          addr_now = 32'hEF01_EF01;
          timeout_now = 16'd4;
        end
        3: begin
          addr_now = 32'h01EF_0107;
          timeout_now = 16'd2;
        end
        default: begin
          addr_now = $urandom;
          timeout_now = 16'($urandom_range(1, 40));
        end
      endcase
      write_reg(REG_ADDRESS, addr_now);
      write_reg(REG_TIMEOUT, {16'h0000, timeout_now});
      phase_goal = used_items + PHASE_ITEMS;
      while (used_items < phase_goal) begin
        run_exchange();
        if ($urandom_range(0, 14) == 0) wait_drained(0);
      end
    end

    wait_drained(30);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
